[src/cfc_pkg.sv]
// Shared types, command codes and helper functions of the compressed float codec.
// Used by every codec module; depends on nothing.
package cfc_pkg;

  localparam int MAX_BYTES_DEF      = 8;
  localparam int AUTO_MAX_BYTES_DEF = 6;
  localparam int BYTES_W            = 4;

  typedef enum logic [1:0] {
    CMD_AUTO   = 2'd0,
    CMD_FIXED  = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0]         exponent;
    logic [63:0]        mantissa;
    logic [BYTES_W-1:0] bytes;
    logic               invalid;
  } enc_res_t;

  // True when a * 2^ea is strictly greater than b * 2^eb (both magnitudes).
  function automatic logic mag_gt(input logic [52:0] a, input logic signed [13:0] ea,
                                  input logic [52:0] b, input logic signed [13:0] eb);
    logic signed [14:0] t;
    logic signed [14:0] nt;
    logic [105:0]       wa;
    logic [105:0]       wb;
    logic               r;
    t  = 15'(ea) - 15'(eb);
    nt = -t;
    wa = {53'd0, a};
    wb = {53'd0, b};
    if (a == 53'd0) begin
      r = 1'b0;
    end else if (b == 53'd0) begin
      r = 1'b1;
    end else if (t >= 15'sd53) begin
      r = 1'b1;
    end else if (t <= -15'sd53) begin
      r = 1'b0;
    end else if (t >= 15'sd0) begin
      r = (wa << t[5:0]) > wb;
    end else begin
      r = wa > (wb << nt[5:0]);
    end
    return r;
  endfunction

endpackage

[src/cfc_encode.sv]
// Encoder pipeline: splits a double, quantizes it for every width and picks one.
// Depends on cfc_pkg.
module cfc_encode import cfc_pkg::*; #(
  parameter int MAX_BYTES      = MAX_BYTES_DEF,
  parameter int AUTO_MAX_BYTES = AUTO_MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  cmd_t               cmd,
  input  logic [63:0]        value_bits,
  input  logic [BYTES_W-1:0] n,
  input  logic [63:0]        max_error,
  output enc_res_t           res
);

  localparam int NB = (MAX_BYTES > AUTO_MAX_BYTES) ? MAX_BYTES : AUTO_MAX_BYTES;
  localparam int IW = $clog2(NB);

  // Split stage: significand with hidden bit and frexp exponent.
  logic [62:0]        mag;
  logic [10:0]        ex;
  logic [51:0]        fr;
  logic [5:0]         top;
  logic [52:0]        sig_next;
  logic signed [11:0] fe_next;

  assign mag = value_bits[62:0];
  assign ex  = mag[62:52];
  assign fr  = mag[51:0];

  always_comb begin
    top = '0;
    for (int i = 0; i < 52; i++) begin
      if (fr[i]) top = 6'(i);
    end
    if (mag == 63'd0) begin
      sig_next = '0;
      fe_next  = '0;
    end else if (ex == 11'd0) begin
      sig_next = 53'({1'b0, fr} << (6'd52 - top));
      fe_next  = $signed({6'd0, top}) - 12'sd1073;
    end else begin
      sig_next = {1'b1, fr};
      fe_next  = $signed({1'b0, ex}) - 12'sd1022;
    end
  end

  logic [52:0]        sig_b;
  logic signed [11:0] fe_b;
  logic               neg_b;
  logic               spec_b;
  cmd_t               cmd_b;
  logic [BYTES_W-1:0] n_b;

  always_ff @(posedge clk) begin
    if (en) begin
      sig_b  <= sig_next;
      fe_b   <= fe_next;
      neg_b  <= value_bits[63] && (mag != 63'd0);
      spec_b <= (ex == 11'h7FF);
      cmd_b  <= cmd;
      n_b    <= n;
    end
  end

  // Quantize stage: one lane for each width.
  logic signed [13:0] fev;
  logic [63:0]        mant_next [NB];
  logic [7:0]         ebyte_next [NB];
  logic [52:0]        opa_next [NB];
  logic signed [13:0] ope_next [NB];
  logic               wrap_next [NB];
  logic               dnz_next [NB];

  assign fev = {{2{fe_b[11]}}, fe_b} - 14'sd53;

  for (genvar i = 0; i < NB; i++) begin : g_lane
    localparam int S = 6 + 8 * i;
    logic signed [12:0] x0;
    logic [7:0]         xw;
    logic [63:0]        mq;
    logic [53:0]        dd;

    assign x0            = {fe_b[11], fe_b} - 13'(S);
    assign xw            = x0[7:0];
    assign wrap_next[i]  = (x0 > 13'sd127) || (x0 < -13'sd128);
    assign ebyte_next[i] = xw;
    assign mant_next[i]  = mq;
    assign dnz_next[i]   = wrap_next[i] || (dd != 54'd0);

    if (S < 53) begin : g_round
      localparam int K = 53 - S;
      logic [53:0] dl;
      assign mq = 64'(({1'b0, sig_b} + (54'd1 << (K - 1))) >> K);
      assign dl = 54'(mq) << K;
      assign dd = (dl >= {1'b0, sig_b}) ? dl - {1'b0, sig_b} : {1'b0, sig_b} - dl;
      assign opa_next[i] = wrap_next[i] ? mq[52:0] : dd[52:0];
      assign ope_next[i] = wrap_next[i] ? {{6{xw[7]}}, xw} : fev;
    end else begin : g_exact
      assign mq = 64'(sig_b) << (S - 53);
      assign dd = '0;
      assign opa_next[i] = wrap_next[i] ? sig_b : 53'd0;
      assign ope_next[i] = wrap_next[i] ? {{6{xw[7]}}, xw} + 14'(S - 53) : fev;
    end
  end

  logic [63:0]        mant_c [NB];
  logic [7:0]         ebyte_c [NB];
  logic [52:0]        opa_c [NB];
  logic signed [13:0] ope_c [NB];
  logic               wrap_c [NB];
  logic               dnz_c [NB];
  logic [52:0]        sig_c;
  logic signed [13:0] fev_c;
  logic               neg_c;
  logic               spec_c;
  cmd_t               cmd_c;
  logic [BYTES_W-1:0] n_c;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NB; i++) begin
        mant_c[i]  <= mant_next[i];
        ebyte_c[i] <= ebyte_next[i];
        opa_c[i]   <= opa_next[i];
        ope_c[i]   <= ope_next[i];
        wrap_c[i]  <= wrap_next[i];
        dnz_c[i]   <= dnz_next[i];
      end
      sig_c  <= sig_b;
      fev_c  <= fev;
      neg_c  <= neg_b;
      spec_c <= spec_b;
      cmd_c  <= cmd_b;
      n_c    <= n_b;
    end
  end

  // Error check against max_error and width choice.
  logic [10:0]        me;
  logic [51:0]        mfr;
  logic               m_nan;
  logic               m_inf;
  logic [52:0]        mf;
  logic signed [13:0] em;
  logic               v_gt;
  logic [NB-1:0]      fail;
  logic [BYTES_W-1:0] n_auto;
  logic [BYTES_W-1:0] n_fin;
  logic [BYTES_W-1:0] nm1;
  logic [IW-1:0]      idx;
  logic [6:0]         sh7;
  logic [63:0]        sbit;

  assign me    = max_error[62:52];
  assign mfr   = max_error[51:0];
  assign m_nan = (me == 11'h7FF) && (mfr != 52'd0);
  assign m_inf = (me == 11'h7FF) && (mfr == 52'd0);
  assign mf    = {me != 11'd0, mfr};
  assign em    = $signed({3'd0, (me == 11'd0) ? 11'd1 : me}) - 14'sd1075;
  assign v_gt  = mag_gt(sig_c, fev_c, mf, em);

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      if (m_nan) begin
        fail[i] = 1'b0;
      end else if (max_error[63]) begin
        fail[i] = dnz_c[i] || (max_error[62:0] != 63'd0);
      end else if (m_inf) begin
        fail[i] = 1'b0;
      end else begin
        fail[i] = mag_gt(opa_c[i], ope_c[i], mf, em) || (wrap_c[i] && v_gt);
      end
    end
    n_auto = BYTES_W'(AUTO_MAX_BYTES);
    for (int i = AUTO_MAX_BYTES - 1; i >= 0; i--) begin
      if (!fail[i]) n_auto = BYTES_W'(i + 1);
    end
  end

  assign n_fin = (cmd_c == CMD_AUTO) ? n_auto : n_c;
  assign nm1   = n_fin - 4'd1;
  assign idx   = nm1[IW-1:0];
  assign sh7   = {n_fin[3:0], 3'b000} - 7'd1;
  assign sbit  = 64'd1 << sh7[5:0];

  always_comb begin
    if (spec_c) begin
      res.exponent = '0;
      res.mantissa = '0;
      res.bytes    = (cmd_c == CMD_AUTO) ? 4'd1 : n_c;
      res.invalid  = 1'b1;
    end else begin
      res.exponent = ebyte_c[idx];
      res.mantissa = mant_c[idx] | (neg_c ? sbit : 64'd0);
      res.bytes    = n_fin;
      res.invalid  = 1'b0;
    end
  end

endmodule

[src/cfc_decode.sv]
// Decoder pipeline: signed mantissa to double with round to nearest even.
// Depends on cfc_pkg.
module cfc_decode import cfc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [63:0]        mantissa_in,
  input  logic [7:0]         exponent_in,
  input  logic [BYTES_W-1:0] n,
  output logic [63:0]        value
);

  logic [6:0]  sh7;
  logic [63:0] sbit;
  logic [63:0] w;
  logic [63:0] u;
  logic [5:0]  p;

  assign sh7  = {n, 3'b000} - 7'd1;
  assign sbit = 64'd1 << sh7[5:0];

  always_comb begin
    w = mantissa_in;
    if ((w & sbit) != 64'd0) w = 64'd0 - (w & ~sbit);
    u = w[63] ? 64'd0 - w : w;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (u[i]) p = 6'(i);
    end
  end

  logic [63:0] u_b;
  logic [5:0]  p_b;
  logic        neg_b;
  logic [7:0]  x_b;

  always_ff @(posedge clk) begin
    if (en) begin
      u_b   <= u;
      p_b   <= p;
      neg_b <= w[63];
      x_b   <= exponent_in;
    end
  end

  // Normalize so the leading one sits at bit 63, then round on the low 11 bits.
  logic [63:0] nrm;
  logic        inc;
  logic [53:0] q2;
  logic [51:0] frac;
  logic [6:0]  pe;
  logic [11:0] ef;

  assign nrm  = u_b << (6'd63 - p_b);
  assign inc  = nrm[10] && ((|nrm[9:0]) || nrm[11]);
  assign q2   = {1'b0, nrm[63:11]} + 54'(inc);
  assign frac = q2[53] ? q2[52:1] : q2[51:0];
  assign pe   = {1'b0, p_b} + 7'(q2[53]);
  assign ef   = {5'd0, pe} + {{4{x_b[7]}}, x_b} + 12'd1023;

  always_ff @(posedge clk) begin
    if (en) begin
      value <= (u_b == 64'd0) ? 64'd0 : {neg_b, ef[10:0], frac};
    end
  end

endmodule

[src/compressed_float_codec.sv]
// Top level of the compressed float codec: handshakes, pipeline valids and result mux.
// Depends on cfc_pkg, cfc_encode and cfc_decode.
//
//   Channel   Signals                                        Role
//   req       req_valid, req_stall, cmd, value_bits,         input items
//             byte_count, exponent_in, mantissa_in
//   rsp       rsp_valid, rsp_stall, exponent_out,            result items
//             mantissa_out, bytes_used, value_out, invalid
//   cfg       cfg_valid, cfg_ready, cfg_data                 max_error register writes
//
// An item passes four registers: the input register, a split or normalize stage, a
// quantize or round stage and the output register, in that order; its result is shown
// on rsp from the output register. One item is accepted per cycle while req_stall is
// low; the whole pipeline advances together whenever the output register is empty
// or its item is being taken. A result held by rsp_stall therefore raises req_stall
// in the same cycle.
// Reset (synchronous, rst high) clears the stage valids and max_error.
module compressed_float_codec import cfc_pkg::*; #(
  parameter int MAX_BYTES      = MAX_BYTES_DEF,
  parameter int AUTO_MAX_BYTES = AUTO_MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         cmd,
  input  logic [63:0]        value_bits,
  input  logic [BYTES_W-1:0] byte_count,
  input  logic signed [7:0]  exponent_in,
  input  logic [63:0]        mantissa_in,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [7:0]  exponent_out,
  output logic [63:0]        mantissa_out,
  output logic [BYTES_W-1:0] bytes_used,
  output logic [63:0]        value_out,
  output logic               invalid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [63:0]        cfg_data
);

  // The pipeline moves as one unit.
  logic adv;
  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;
  assign cfg_ready = 1'b1;

  logic [63:0] max_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_error <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_error <= cfg_data;
    end
  end

  // Out-of-range byte counts are pulled into one to MAX_BYTES.
  logic [BYTES_W-1:0] n_in;
  assign n_in = (byte_count == 4'd0) ? 4'd1 :
                (byte_count > BYTES_W'(MAX_BYTES)) ? BYTES_W'(MAX_BYTES) : byte_count;

  // Input register.
  logic               valid_a;
  logic               valid_b;
  logic               valid_c;
  cmd_t               cmd_a;
  cmd_t               cmd_b;
  cmd_t               cmd_c;
  logic [BYTES_W-1:0] n_a;
  logic [BYTES_W-1:0] n_b;
  logic [BYTES_W-1:0] n_c;
  logic [63:0]        vb_a;
  logic [7:0]         x_a;
  logic [63:0]        w_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else if (adv) begin
      valid_a <= req_valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_a <= cmd_t'(cmd);
      n_a   <= n_in;
      vb_a  <= value_bits;
      x_a   <= exponent_in;
      w_a   <= mantissa_in;
      cmd_b <= cmd_a;
      n_b   <= n_a;
      cmd_c <= cmd_b;
      n_c   <= n_b;
    end
  end

  enc_res_t    enc_res;
  logic [63:0] dec_value;

  cfc_encode #(
    .MAX_BYTES      (MAX_BYTES),
    .AUTO_MAX_BYTES (AUTO_MAX_BYTES)
  ) u_encode (
    .clk        (clk),
    .en         (adv),
    .cmd        (cmd_a),
    .value_bits (vb_a),
    .n          (n_a),
    .max_error  (max_error),
    .res        (enc_res)
  );

  cfc_decode u_decode (
    .clk         (clk),
    .en          (adv),
    .mantissa_in (w_a),
    .exponent_in (x_a),
    .n           (n_a),
    .value       (dec_value)
  );

  // Output register: picks the result that matches the item's command.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (cmd_c)
        CMD_AUTO, CMD_FIXED: begin
          exponent_out <= enc_res.exponent;
          mantissa_out <= enc_res.mantissa;
          bytes_used   <= enc_res.bytes;
          value_out    <= '0;
          invalid      <= enc_res.invalid;
        end
        CMD_DECODE: begin
          exponent_out <= '0;
          mantissa_out <= '0;
          bytes_used   <= n_c;
          value_out    <= dec_value;
          invalid      <= 1'b0;
        end
        default: begin
          exponent_out <= '0;
          mantissa_out <= '0;
          bytes_used   <= n_c;
          value_out    <= '0;
          invalid      <= 1'b1;
        end
      endcase
    end
  end

endmodule
